// ===== src/assert_macros.svh =====
// Assertion macros for the checker file, dtms_checker.sv.
// Each macro expands to one labeled concurrent assertion on i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DTMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dtms_pkg.sv =====
// Types and constants for the dead-reckoning time match search.
// No dependencies; imported by every module of the block.
`default_nettype none

package dtms_pkg;

    typedef enum logic [2:0] {
        ACT_NEW_LIST   = 3'd0,
        ACT_APPEND     = 3'd1,
        ACT_SET_NEWEST = 3'd2,
        ACT_SET_OLDEST = 3'd3,
        ACT_QUERY      = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_MATCHED    = 3'd0,
        ST_NEWER      = 3'd1,
        ST_OLDER      = 3'd2,
        ST_NO_MATCH   = 3'd3,
        ST_NO_MESSAGE = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef logic [52:0] t_stamp;

    typedef struct packed {
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] yaw_step;
        logic        [15:0] belief;
        logic signed [31:0] sum_x;
        logic signed [31:0] sum_y;
        logic signed [31:0] sum_yaw;
    } t_motion;

    typedef struct packed {
        t_stamp  stamp;
        t_motion motion;
    } t_entry;

    typedef struct packed {
        t_status status;
        logic    found;
        t_motion motion;
    } t_result;

    localparam logic        [15:0] BELIEF_NEAR_ONE = 16'd64881;
    localparam logic signed [31:0] SUM_X_FALLBACK  = 32'shFE0C0000;

endpackage

`default_nettype wire

// ===== src/dtms_cell.sv =====
// One table cell: holds a single entry, loads on append, rotates from its neighbor.
// Depends on dtms_pkg.
`default_nettype none

module dtms_cell import dtms_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_load,
    input  wire logic   i_shift,
    input  wire t_entry i_wr_data,
    input  wire t_entry i_next,
    output t_entry      o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_wr_data;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== src/dtms_ctrl.sv =====
// Request control, bounds, scan sequencer and result register.
// Depends on dtms_pkg; drives the cell row built in the top level.
`default_nettype none

module dtms_ctrl import dtms_pkg::*; #(
    parameter  int unsigned DEPTH = 64,
    localparam int unsigned IW    = $clog2(DEPTH),
    localparam int unsigned CW    = $clog2(DEPTH + 1),
    localparam int unsigned SW    = IW + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [2:0]    i_action,
    input  wire t_stamp        i_time_stamp,
    input  wire t_entry        i_head,
    input  wire t_entry        i_second,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output t_result            o_result,
    output logic               o_shift,
    output logic               o_wr_en,
    output logic [IW-1:0]      o_wr_idx
);

    t_state          r_state, n_state;
    logic [IW-1:0]   r_step, n_step;
    logic            r_hit, n_hit;
    t_motion         r_hit_data, n_hit_data;
    t_stamp          r_query, n_query;
    logic [CW-1:0]   r_count, n_count;
    t_stamp          r_newest, n_newest;
    t_stamp          r_oldest, n_oldest;
    logic            r_list, n_list;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;

    t_action         act;
    logic            accept;
    logic            is_query;
    logic            newer;
    logic            older;
    logic            scan_go;
    logic            pair_ok;
    logic            hit;
    logic            last;
    logic            room;
    t_result         imm;

    assign act      = t_action'(i_action);
    assign accept   = i_in_valid && !o_in_stall;
    assign is_query = accept && (act == ACT_QUERY);
    assign newer    = i_time_stamp > r_newest;
    assign older    = i_time_stamp < r_oldest;
    assign scan_go  = is_query && r_list && !newer && !older;
    assign room     = r_count < CW'(DEPTH);

    assign pair_ok  = (SW'(r_step) + SW'(1)) < SW'(r_count);
    assign hit      = (r_state == S_SCAN) && pair_ok && !r_hit
                      && (r_query <= i_head.stamp) && (r_query > i_second.stamp);
    assign last     = r_step == IW'(DEPTH - 1);

    // immediate answers, decided at accept
    always_comb begin
        imm = '0;
        if (!r_list) begin
            imm.status = ST_NO_MESSAGE;
        end else if (newer) begin
            imm.status        = ST_NEWER;
            imm.found         = 1'b1;
            imm.motion.belief = BELIEF_NEAR_ONE;
        end else begin
            imm.status       = ST_OLDER;
            imm.motion.sum_x = SUM_X_FALLBACK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (scan_go) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        o_shift    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = r_out_valid && i_out_stall;
            end
            S_SCAN: begin
                o_shift = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_wr_en  = accept && (act == ACT_APPEND) && room;
    assign o_wr_idx = r_count[IW-1:0];

    // list bookkeeping
    always_comb begin
        n_count  = r_count;
        n_newest = r_newest;
        n_oldest = r_oldest;
        n_list   = r_list;
        n_query  = r_query;
        if (accept) begin
            case (act)
                ACT_NEW_LIST: begin
                    n_list   = 1'b1;
                    n_count  = '0;
                    n_newest = '0;
                    n_oldest = '0;
                end
                ACT_APPEND: begin
                    if (room) begin
                        n_count = r_count + CW'(1);
                    end
                end
                ACT_SET_NEWEST: begin
                    n_newest = i_time_stamp;
                end
                ACT_SET_OLDEST: begin
                    n_oldest = i_time_stamp;
                end
                ACT_QUERY: begin
                    n_query = i_time_stamp;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // scan progress and result register
    always_comb begin
        n_step      = '0;
        n_hit       = 1'b0;
        n_hit_data  = r_hit_data;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (r_state == S_SCAN) begin
            n_step = r_step + IW'(1);
            n_hit  = r_hit || hit;
            if (hit) begin
                n_hit_data = i_head.motion;
            end
            if (last) begin
                n_out_valid = 1'b1;
                n_out       = '0;
                if (r_hit || hit) begin
                    n_out.status = ST_MATCHED;
                    n_out.found  = 1'b1;
                    n_out.motion = r_hit ? r_hit_data : i_head.motion;
                end else begin
                    n_out.status       = ST_NO_MATCH;
                    n_out.motion.sum_x = SUM_X_FALLBACK;
                end
            end
        end else if (is_query && !scan_go) begin
            n_out_valid = 1'b1;
            n_out       = imm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_count     <= '0;
            r_newest    <= '0;
            r_oldest    <= '0;
            r_list      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_hit       <= n_hit;
            r_count     <= n_count;
            r_newest    <= n_newest;
            r_oldest    <= n_oldest;
            r_list      <= n_list;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_data <= n_hit_data;
        r_query    <= n_query;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

// ===== src/dr_time_match_search.sv =====
// Top level of the dead-reckoning time match search: control plus a rotating row of cells.
// Depends on dtms_pkg, dtms_ctrl and dtms_cell.
//
//   channel   direction   handshake                 payload
//   request   in          i_in_valid / o_in_stall   i_action, i_time_stamp, entry fields
//   result    out         o_out_valid / i_out_stall o_status, o_found, o_out_* fields
//
// New list, append and bound requests give no result.
// A query inside the bounds rotates the cell row once, and the result register loads on
// the last step; queries out of bounds or with no list open answer next cycle.
// The row rotates one step per cycle, and no new request is taken until the rotation ends.
// Reset clears control, count and bounds; cell contents are left as they are.
// Requests stall during a scan, or while a held result is stalled downstream.
`default_nettype none

module dr_time_match_search import dtms_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_action,
    input  wire logic [52:0]        i_time_stamp,
    input  wire logic signed [31:0] i_delta_x,
    input  wire logic signed [31:0] i_delta_y,
    input  wire logic signed [31:0] i_yaw_step,
    input  wire logic [15:0]        i_belief,
    input  wire logic signed [31:0] i_sum_x,
    input  wire logic signed [31:0] i_sum_y,
    input  wire logic signed [31:0] i_sum_yaw,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_status,
    output logic                    o_found,
    output logic signed [31:0]      o_out_delta_x,
    output logic signed [31:0]      o_out_delta_y,
    output logic signed [31:0]      o_out_yaw_step,
    output logic [15:0]             o_out_belief,
    output logic signed [31:0]      o_out_sum_x,
    output logic signed [31:0]      o_out_sum_y,
    output logic signed [31:0]      o_out_sum_yaw
);

    localparam int unsigned IW = $clog2(TABLE_DEPTH);

    t_entry        cell_q [TABLE_DEPTH];
    t_entry        wr_data;
    t_result       result;
    logic          shift;
    logic          wr_en;
    logic [IW-1:0] wr_idx;

    assign wr_data = {i_time_stamp, i_delta_x, i_delta_y, i_yaw_step, i_belief,
                      i_sum_x, i_sum_y, i_sum_yaw};

    dtms_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_time_stamp (i_time_stamp),
        .i_head       (cell_q[0]),
        .i_second     (cell_q[1]),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_result     (result),
        .o_shift      (shift),
        .o_wr_en      (wr_en),
        .o_wr_idx     (wr_idx)
    );

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        localparam int unsigned NXT = (k + 1) % TABLE_DEPTH;

        dtms_cell u_cell (
            .i_clk     (i_clk),
            .i_load    (wr_en && (wr_idx == IW'(k))),
            .i_shift   (shift),
            .i_wr_data (wr_data),
            .i_next    (cell_q[NXT]),
            .o_entry   (cell_q[k])
        );
    end

    assign o_status        = result.status;
    assign o_found         = result.found;
    assign o_out_delta_x   = result.motion.delta_x;
    assign o_out_delta_y   = result.motion.delta_y;
    assign o_out_yaw_step  = result.motion.yaw_step;
    assign o_out_belief    = result.motion.belief;
    assign o_out_sum_x     = result.motion.sum_x;
    assign o_out_sum_y     = result.motion.sum_y;
    assign o_out_sum_yaw   = result.motion.sum_yaw;

endmodule

`default_nettype wire

// ===== src/dtms_checker.sv =====
// Port-level checker for dr_time_match_search, attached by bind.
// Depends on dtms_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dtms_checker import dtms_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic [2:0]         i_action,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [2:0]         o_status,
    input wire logic               o_found,
    input wire logic [15:0]        o_out_belief,
    input wire logic signed [31:0] o_out_sum_x
);

    `DTMS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status), "result dropped or changed while stalled")

    `DTMS_ASSERT_NOW(a_found_status, o_out_valid, o_found == (o_status == ST_MATCHED || o_status == ST_NEWER), "found disagrees with status")

    `DTMS_ASSERT_NOW(a_fallback, o_out_valid && (o_status == ST_OLDER || o_status == ST_NO_MATCH), o_out_sum_x == SUM_X_FALLBACK && o_out_belief == 16'd0, "bad fallback payload")

    `DTMS_ASSERT_NEXT(a_query_busy, i_in_valid && !o_in_stall && i_action == ACT_QUERY, o_out_valid || o_in_stall, "query neither answered nor scanning")

endmodule

bind dr_time_match_search dtms_checker u_dtms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_action     (i_action),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_status     (o_status),
    .o_found      (o_found),
    .o_out_belief (o_out_belief),
    .o_out_sum_x  (o_out_sum_x)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for dr_time_match_search: a driver and a monitor around the block,
// with an in-bench lookup table that predicts every query answer.
// Depends on dtms_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb;
    import dtms_pkg::*;

    localparam int unsigned DEPTH        = 64;
    localparam int unsigned ITEM_TARGET  = 1700;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam t_stamp      STAMP_MAX    = '1;
    localparam logic [2:0]  ACT_SPARE_MIN = 3'd5;
    localparam logic [2:0]  ACT_SPARE_MAX = 3'd7;

    typedef struct packed {
        logic [2:0] act;
        t_stamp     stamp;
        t_motion    motion;
    } t_request;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     out_stall = 1'b0;
    t_request req_drv = '0;

    wire               in_stall;
    wire               out_valid;
    wire        [2:0]  got_status;
    wire               got_found;
    wire signed [31:0] got_dx, got_dy, got_dyaw, got_sx, got_sy, got_syaw;
    wire        [15:0] got_belief;

    dr_time_match_search #(.TABLE_DEPTH(DEPTH)) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (req_drv.act),
        .i_time_stamp    (req_drv.stamp),
        .i_delta_x       (req_drv.motion.delta_x),
        .i_delta_y       (req_drv.motion.delta_y),
        .i_yaw_step      (req_drv.motion.yaw_step),
        .i_belief        (req_drv.motion.belief),
        .i_sum_x         (req_drv.motion.sum_x),
        .i_sum_y         (req_drv.motion.sum_y),
        .i_sum_yaw       (req_drv.motion.sum_yaw),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (got_status),
        .o_found         (got_found),
        .o_out_delta_x   (got_dx),
        .o_out_delta_y   (got_dy),
        .o_out_yaw_step  (got_dyaw),
        .o_out_belief    (got_belief),
        .o_out_sum_x     (got_sx),
        .o_out_sum_y     (got_sy),
        .o_out_sum_yaw   (got_syaw)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // lookup table mirror
    t_stamp      tbl_stamp [DEPTH];
    t_motion     tbl_motion[DEPTH];
    int unsigned n_entries = 0;
    t_stamp      newest_t = '0;
    t_stamp      oldest_t = '0;
    bit          have_list = 1'b0;

    t_request    pending_requests[$];
    t_result     expected_lookups[$];
    int unsigned n_items = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    function automatic void apply_request(t_request r);
        t_result res;
        bit      hit;
        res = '0;
        hit = 1'b0;
        case (r.act)
            ACT_NEW_LIST: begin
                have_list = 1'b1;
                n_entries = 0;
                newest_t  = '0;
                oldest_t  = '0;
            end
            ACT_APPEND: begin
                if (n_entries < DEPTH) begin
                    tbl_stamp[n_entries]  = r.stamp;
                    tbl_motion[n_entries] = r.motion;
                    n_entries++;
                end
            end
            ACT_SET_NEWEST: newest_t = r.stamp;
            ACT_SET_OLDEST: oldest_t = r.stamp;
            ACT_QUERY: begin
                if (!have_list) begin
                    res.status = ST_NO_MESSAGE;
                end else if (r.stamp > newest_t) begin
                    res.status        = ST_NEWER;
                    res.found         = 1'b1;
                    res.motion.belief = BELIEF_NEAR_ONE;
                end else if (r.stamp < oldest_t) begin
                    res.status       = ST_OLDER;
                    res.motion.sum_x = SUM_X_FALLBACK;
                end else begin
                    for (int k = 0; k + 1 < n_entries; k++) begin
                        if (!hit && r.stamp <= tbl_stamp[k] && r.stamp > tbl_stamp[k + 1]) begin
                            hit        = 1'b1;
                            res.status = ST_MATCHED;
                            res.found  = 1'b1;
                            res.motion = tbl_motion[k];
                        end
                    end
                    if (!hit) begin
                        res.status       = ST_NO_MATCH;
                        res.motion.sum_x = SUM_X_FALLBACK;
                    end
                end
                expected_lookups.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_stamp rand_stamp();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[52:0];
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_motion fill_motion(logic [31:0] w);
        t_motion m;
        m.delta_x   = w;
        m.delta_y   = w;
        m.yaw_step  = w;
        m.belief    = w[15:0];
        m.sum_x     = w;
        m.sum_y     = w;
        m.sum_yaw   = w;
        return m;
    endfunction

    function automatic t_motion rand_motion();
        t_motion     m;
        logic [31:0] w;
        m.delta_x   = rand_word();
        m.delta_y   = rand_word();
        m.yaw_step  = rand_word();
        w           = rand_word();
        m.belief    = w[15:0];
        m.sum_x     = rand_word();
        m.sum_y     = rand_word();
        m.sum_yaw   = rand_word();
        return m;
    endfunction

    function automatic t_stamp pick_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return t_stamp'($urandom_range(0, 2));
        else if (r < 60)
            return t_stamp'($urandom_range(1, 5000));
        return rand_stamp() >> $urandom_range(10, 52);
    endfunction

    function automatic t_stamp pick_query(t_stamp stamps[$], t_stamp nb, t_stamp ob);
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        if (r < 50 && stamps.size() > 0) begin
            k = $urandom_range(0, stamps.size() - 1);
            case ($urandom_range(0, 3))
                0: return stamps[k];
                1: return stamps[k] - 1;
                2: return stamps[k] + 1;
                default: return stamps[k] - pick_step();
            endcase
        end else if (r < 65) begin
            return ($urandom_range(0, 1) != 0) ? nb : nb + 1;
        end else if (r < 80) begin
            return ($urandom_range(0, 1) != 0) ? ob : ob - 1;
        end else if (r < 90) begin
            return ($urandom_range(0, 1) != 0) ? '0 : STAMP_MAX;
        end
        return rand_stamp();
    endfunction

    task automatic push(logic [2:0] a, t_stamp s, t_motion m);
        t_request r;
        r.act    = a;
        r.stamp  = s;
        r.motion = m;
        pending_requests.push_back(r);
        n_items++;
    endtask

    task automatic add_list(bit force_full);
        int unsigned n, nq, r;
        t_stamp      s, stp, nb, ob;
        t_stamp      stamps[$];
        push(ACT_NEW_LIST, rand_stamp(), rand_motion());
        r = $urandom_range(0, 99);
        if (force_full)
            n = 70;
        else if (r < 80)
            n = $urandom_range(0, 8);
        else if (r < 95)
            n = $urandom_range(9, 40);
        else
            n = $urandom_range(60, 70);
        s = ($urandom_range(0, 1) != 0) ? rand_stamp() : t_stamp'($urandom_range(0, 1000000));
        for (int k = 0; k < n; k++) begin
            stamps.push_back(s);
            push(ACT_APPEND, s, rand_motion());
            stp = pick_step();
            s   = (stp > s) ? '0 : s - stp;
        end
        nb = '0;
        ob = '0;
        r  = $urandom_range(0, 99);
        if (r < 90) begin
            if (n == 0)
                nb = rand_stamp();
            else if (r < 65)
                nb = stamps[0];
            else if (r < 78)
                nb = stamps[0] - pick_step();
            else
                nb = rand_stamp();
            push(ACT_SET_NEWEST, nb, rand_motion());
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            if (n > 0 && r < 30)
                ob = stamps[n - 1];
            else if (n > 0)
                ob = stamps[$urandom_range(0, n - 1)];
            else
                ob = rand_stamp() >> $urandom_range(0, 52);
            push(ACT_SET_OLDEST, ob, rand_motion());
        end
        nq = $urandom_range(1, 6);
        for (int k = 0; k < nq; k++)
            push(ACT_QUERY, pick_query(stamps, nb, ob), rand_motion());
    endtask

    task automatic add_noise();
        int unsigned n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
            push(3'($urandom_range(0, 7)),
                 ($urandom_range(0, 1) != 0) ? rand_stamp() : t_stamp'($urandom_range(0, 5000)),
                 rand_motion());
    endtask

    task automatic add_directed();
        push(ACT_QUERY, STAMP_MAX, rand_motion());
        push(ACT_APPEND, rand_stamp(), rand_motion());
        push(ACT_QUERY, '0, rand_motion());
        push(ACT_NEW_LIST, '0, fill_motion('0));
        push(ACT_QUERY, '0, rand_motion());
        push(ACT_QUERY, t_stamp'(1), rand_motion());
        push(ACT_SET_NEWEST, STAMP_MAX, rand_motion());
        push(ACT_SET_OLDEST, '0, rand_motion());
        push(ACT_APPEND, STAMP_MAX, fill_motion(32'h7FFF_FFFF));
        push(ACT_APPEND, t_stamp'(1000), fill_motion(32'h8000_0000));
        push(ACT_APPEND, t_stamp'(5), rand_motion());
        push(ACT_APPEND, '0, fill_motion('0));
        push(ACT_QUERY, STAMP_MAX, rand_motion());
        push(ACT_QUERY, t_stamp'(1000), rand_motion());
        push(ACT_QUERY, t_stamp'(3), rand_motion());
        push(ACT_QUERY, '0, rand_motion());
        for (logic [3:0] a = ACT_SPARE_MIN; a <= ACT_SPARE_MAX; a++)
            push(a[2:0], rand_stamp(), rand_motion());
        push(ACT_SET_OLDEST, t_stamp'(10), rand_motion());
        push(ACT_QUERY, t_stamp'(9), rand_motion());
        push(ACT_SET_NEWEST, t_stamp'(100), rand_motion());
        push(ACT_QUERY, t_stamp'(101), rand_motion());
    endtask

    // request driver
    t_request    cur_req;
    int unsigned tx_gap = 0;
    int unsigned tx_calm = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                apply_request(cur_req);
            if (!in_valid || !in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    cur_req = pending_requests.pop_front();
                    req_drv  <= cur_req;
                    in_valid <= 1'b1;
                    if (tx_calm > 0) begin
                        tx_calm--;
                    end else begin
                        tx_gap = pick_gap();
                        if ($urandom_range(0, 99) < 3)
                            tx_calm = $urandom_range(30, 150);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern, with one long hold-off
    int unsigned rx_stall = 0;
    int unsigned rx_calm = 0;
    int unsigned rx_hold = 0;
    int unsigned rx_seen = 0;
    bit          hold_done = 1'b0;

    always @(posedge clk) begin
        if (out_valid && !out_stall)
            rx_seen++;
        if (rx_hold > 0) begin
            rx_hold--;
            out_stall <= 1'b1;
        end else if (!hold_done && rx_seen >= 12) begin
            hold_done = 1'b1;
            rx_hold   = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            out_stall <= 1'b1;
        end else if (rx_calm > 0) begin
            rx_calm--;
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            rx_stall = pick_gap();
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 99) < 3)
                rx_calm = $urandom_range(30, 150);
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_lookups.size() == 0) begin
                report("unexpected result", got_status, '0);
            end else begin
                want = expected_lookups.pop_front();
                check_field("status", got_status, want.status);
                check_field("found", got_found, want.found);
                check_field("delta_x", got_dx, want.motion.delta_x);
                check_field("delta_y", got_dy, want.motion.delta_y);
                check_field("yaw_step", got_dyaw, want.motion.yaw_step);
                check_field("belief", got_belief, want.motion.belief);
                check_field("sum_x", got_sx, want.motion.sum_x);
                check_field("sum_y", got_sy, want.motion.sum_y);
                check_field("sum_yaw", got_syaw, want.motion.sum_yaw);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        bit timed_out;
        timed_out = 1'b0;
        add_directed();
        add_list(1'b1);
        while (n_items < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 88)
                add_list(1'b0);
            else
                add_noise();
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (!timed_out && (pending_requests.size() != 0 || in_valid
                              || expected_lookups.size() != 0)) begin
            @(negedge clk);
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
        end
        if (timed_out)
            $display("%0t timeout: no request or result moved for %0d cycles",
                     $realtime, IDLE_LIMIT);
        else
            repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_lookups.size() != 0)
            report("results missing", expected_lookups.size(), '0);
        if (timed_out || mismatch_count != 0)
            $display("== FAIL ==");
        else
            $display("== PASS ==");
        $finish;
    end

endmodule

// ===== dr_time_match_search.f =====
+incdir+src
src/dtms_pkg.sv
src/dtms_cell.sv
src/dtms_ctrl.sv
src/dr_time_match_search.sv
src/dtms_checker.sv
tb/sv/tb.sv
